// ===== rtl/tbam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbam_pkg
// Shared types and constants of the tile box average / minimum unit.
// ----------------------------------------------------------------------------
package tbam_pkg;

  localparam int PIX_W      = 8;
  localparam int CH_N       = 3;
  localparam int ACROSS_W   = 11;
  localparam int COL_OUT_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACROSS = 2'd1;

  localparam logic [ACROSS_W-1:0] ACROSS_RESET = 11'd1024;

  typedef enum logic {
    MODE_AVERAGE = 1'b0,
    MODE_MINIMUM = 1'b1
  } tbam_mode_t;

  typedef struct packed {
    logic first;
    logic from_store;
    logic last_col;
    logic emit;
    logic band_done;
  } tbam_ctl_t;

endpackage

// ===== rtl/tbam_pos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbam_pos
// Raster position tracker: pixel column in tile, tile column, row in band.
// ----------------------------------------------------------------------------
module tbam_pos #(
  parameter int TILE_SIDE = 3,
  parameter int POS_W     = 10,
  parameter int ACR_W     = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              frame_start,
  input  logic [ACR_W-1:0]  across,
  output logic [POS_W-1:0]  pos,
  output tbam_pkg::tbam_ctl_t ctl
);
  import tbam_pkg::*;

  localparam int CW = (TILE_SIDE > 1) ? $clog2(TILE_SIDE) : 1;
  localparam logic [CW-1:0] LAST = CW'(TILE_SIDE - 1);

  logic [CW-1:0]    col_r, col_nxt, col_c;
  logic [CW-1:0]    row_r, row_nxt, row_c;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_b, pos_c;
  logic [ACR_W-1:0] pos_inc;
  logic             last_row;

  always_comb begin
    col_c = frame_start ? '0 : col_r;
    row_c = frame_start ? '0 : row_r;
    pos_b = frame_start ? '0 : pos_r;
    pos_c = (ACR_W'(pos_b) >= across) ? '0 : pos_b;
    pos_inc = ACR_W'(pos_c) + ACR_W'(1);
    last_row = (row_c == LAST);
    ctl.first      = (col_c == '0) && (row_c == '0);
    ctl.from_store = (col_c == '0) && (row_c != '0);
    ctl.last_col   = (col_c == LAST);
    ctl.emit       = ctl.last_col && last_row;
    ctl.band_done  = (pos_inc == across);
    pos = pos_c;

    col_nxt = col_r;
    row_nxt = row_r;
    pos_nxt = pos_r;
    if (step) begin
      col_nxt = ctl.last_col ? '0 : col_c + CW'(1);
      row_nxt = row_c;
      pos_nxt = pos_c;
      if (ctl.last_col) begin
        if (pos_inc >= across) begin
          pos_nxt = '0;
          row_nxt = last_row ? '0 : row_c + CW'(1);
        end else begin
          pos_nxt = pos_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/tbam_fold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbam_fold
// Per-channel fold stage: band store, running tile, average/min result.
// ----------------------------------------------------------------------------
module tbam_fold #(
  parameter int TILE_SIDE = 3,
  parameter int MAX_TILES = 1024,
  parameter int POS_W     = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tbam_pkg::PIX_W-1:0] in_red,
  input  logic [tbam_pkg::PIX_W-1:0] in_green,
  input  logic [tbam_pkg::PIX_W-1:0] in_blue,
  input  tbam_pkg::tbam_ctl_t       in_ctl,
  input  logic [POS_W-1:0]          in_pos,
  input  tbam_pkg::tbam_mode_t      mode,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tbam_pkg::PIX_W-1:0] out_red,
  output logic [tbam_pkg::PIX_W-1:0] out_green,
  output logic [tbam_pkg::PIX_W-1:0] out_blue,
  output logic [tbam_pkg::COL_OUT_W-1:0] out_column,
  output logic                      out_last
);
  import tbam_pkg::*;

  localparam int AREA  = TILE_SIDE * TILE_SIDE;
  localparam int SUM_W = $clog2(255 * AREA + 1);
  localparam int SHIFT = SUM_W + $clog2(AREA);
  localparam int MW    = SUM_W + 2;
  localparam int PW    = SUM_W + MW;
  localparam logic [MW-1:0] RECIP = MW'(((2 ** SHIFT) + AREA - 1) / AREA);

  typedef logic [CH_N-1:0][SUM_W-1:0] fold_t;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [CH_N-1:0][PIX_W-1:0]  s1_pix_r;
  tbam_ctl_t                   s1_ctl_r;
  logic [POS_W-1:0]            s1_pos_r;
  tbam_mode_t                  s1_mode_r;
  fold_t                       rd_data_r;
  fold_t                       run_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [CH_N-1:0][PIX_W-1:0]  res_r;
  logic [COL_OUT_W-1:0]        col_r;
  logic                        last_r;

  logic                        s1_fire;
  logic                        accept;
  fold_t                       base;
  fold_t                       acc;
  logic                        wr_en;
  logic [CH_N-1:0][PIX_W-1:0]  res;
  logic [CH_N-1:0][PW-1:0]     prod;
  logic [CH_N-1:0][SUM_W-1:0]  val;
  logic [POS_W+COL_OUT_W-1:0]  pos_ext;

  logic [CH_N*SUM_W-1:0] mem_flat [MAX_TILES];

  assign s1_fire  = s1_valid_r && (!s1_ctl_r.emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign accept   = in_valid && in_ready;
  assign wr_en    = s1_fire && s1_ctl_r.last_col && !s1_ctl_r.emit;

  always_comb begin
    base = s1_ctl_r.from_store ? rd_data_r : run_r;
    for (int c = 0; c < CH_N; c++) begin
      if (s1_ctl_r.first) begin
        acc[c] = SUM_W'(s1_pix_r[c]);
      end else if (s1_mode_r == MODE_MINIMUM) begin
        acc[c] = (SUM_W'(s1_pix_r[c]) < base[c]) ? SUM_W'(s1_pix_r[c]) : base[c];
      end else begin
        acc[c] = base[c] + SUM_W'(s1_pix_r[c]);
      end
      prod[c] = PW'(acc[c]) * PW'(RECIP);
      val[c]  = (s1_mode_r == MODE_MINIMUM) ? acc[c] : SUM_W'(prod[c][PW-1:SHIFT]);
      res[c]  = (val[c] > SUM_W'(255)) ? PIX_W'(255) : val[c][PIX_W-1:0];
    end
    pos_ext = {{COL_OUT_W{1'b0}}, s1_pos_r};
    s1_valid_nxt  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = (s1_fire && s1_ctl_r.emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_flat[s1_pos_r] <= acc;
    end
    if (accept) begin
      if (wr_en && (s1_pos_r == in_pos)) begin
        rd_data_r <= acc;
      end else begin
        rd_data_r <= mem_flat[in_pos];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= {in_blue, in_green, in_red};
      s1_ctl_r  <= in_ctl;
      s1_pos_r  <= in_pos;
      s1_mode_r <= mode;
    end
    if (s1_fire && !s1_ctl_r.last_col) begin
      run_r <= acc;
    end
    if (s1_fire && s1_ctl_r.emit) begin
      res_r  <= res;
      col_r  <= pos_ext[COL_OUT_W-1:0];
      last_r <= s1_ctl_r.band_done;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_red    = res_r[0];
  assign out_green  = res_r[1];
  assign out_blue   = res_r[2];
  assign out_column = col_r;
  assign out_last   = last_r;

`ifndef SYNTH
  a_rose_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_ctl_r.emit))
    else $error("result appeared without a finished tile");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item lost from fold stage");

  a_first_not_store: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(s1_ctl_r.first && s1_ctl_r.from_store))
    else $error("tile start both fresh and from store");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ctl_r.emit && out_valid_r && !out_ready)
      |=> (s1_valid_r && $stable(s1_pos_r) && $stable(s1_ctl_r)))
    else $error("stalled tile result dropped");
`endif

endmodule

// ===== rtl/tile_box_average_or_min_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_box_average_or_min_unit
// Tile pooling of an RGB pixel stream: per-tile average or minimum.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ stream, one item per clock while
// in_tready is high; tuser flags the first pixel of a frame. Each TILE_SIDE x
// TILE_SIDE tile yields one item on the out_ stream when its last pixel has
// been folded; tlast marks the last tile of a band.
// The cfg_ channel sets the mode (average or minimum) and the tile count per
// row; write it only while the stream is idle. cfg_ready is always high.
// Throughput: one pixel per cycle unless a result waits, set by the single fold
// stage behind the input register; out_tvalid rises once that stage passes on
// the tile's last pixel. The band store is one read and one write port RAM,
// read when a pixel is accepted and bypassed from the write of the same cycle.
// When out_tready is low and a result waits, pixels keep flowing until the
// next tile result is ready to leave; then in_tready drops.
// Reset clears the position counters and both valid flags, sets mode to
// average and the tile count to 1024; the store needs no clearing.
// ----------------------------------------------------------------------------
module tile_box_average_or_min_unit #(
  parameter int TILE_SIDE = 3,
  parameter int MAX_TILES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbam_pkg::IN_DATA_W-1:0]   in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic                             in_tuser,   // frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tbam_pkg::OUT_DATA_W-1:0]  out_tdata,  // tile_red, tile_green, tile_blue,
                                                       // tile_column, zero pad
  output logic                             out_tlast,  // band_done
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbam_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tbam_pkg::*;

  localparam int POS_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int ACR_W = ($clog2(MAX_TILES + 1) > ACROSS_W) ? $clog2(MAX_TILES + 1) : ACROSS_W;

  tbam_mode_t          mode_r, mode_nxt;
  logic [ACROSS_W-1:0] across_r, across_nxt;
  logic [ACR_W-1:0]    across_eff;
  logic [ACR_W-1:0]    across_ext;
  logic                step;
  logic [POS_W-1:0]    pos;
  tbam_ctl_t           ctl;
  logic [PIX_W-1:0]    t_red, t_green, t_blue;
  logic [COL_OUT_W-1:0] t_col;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    across_nxt = across_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:   mode_nxt   = tbam_mode_t'(cfg_data[0]);
        CFG_ACROSS: across_nxt = cfg_data[ACROSS_W-1:0];
        default: ;
      endcase
    end
    across_ext = ACR_W'(across_r);
    if (across_ext == '0) begin
      across_eff = ACR_W'(1);
    end else if (across_ext > ACR_W'(MAX_TILES)) begin
      across_eff = ACR_W'(MAX_TILES);
    end else begin
      across_eff = across_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_AVERAGE;
      across_r <= ACROSS_RESET;
    end else begin
      mode_r   <= mode_nxt;
      across_r <= across_nxt;
    end
  end

  assign step = in_tvalid && in_tready;

  tbam_pos #(
    .TILE_SIDE (TILE_SIDE),
    .POS_W     (POS_W),
    .ACR_W     (ACR_W)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .frame_start (in_tuser),
    .across      (across_eff),
    .pos         (pos),
    .ctl         (ctl)
  );

  tbam_fold #(
    .TILE_SIDE (TILE_SIDE),
    .MAX_TILES (MAX_TILES),
    .POS_W     (POS_W)
  ) u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_red     (in_tdata[7:0]),
    .in_green   (in_tdata[15:8]),
    .in_blue    (in_tdata[23:16]),
    .in_ctl     (ctl),
    .in_pos     (pos),
    .mode       (mode_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_red    (t_red),
    .out_green  (t_green),
    .out_blue   (t_blue),
    .out_column (t_col),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'b0, t_col, t_blue, t_green, t_red};

endmodule

// ===== test/tile_box_average_or_min_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_box_average_or_min_unit_test
// Self-checking bench for the tile box average / minimum unit.
// ----------------------------------------------------------------------------
// A clocked driver sends pixel items from a queue that the stimulus process
// fills. Each accepted pixel is folded into a local tile pooling model, which
// queues the tile result it predicts. A clocked monitor compares every result
// item field by field with the oldest prediction. Both sides idle at random,
// except for one long unthrottled stretch. The stimulus starts with a short
// directed run:
//   - extreme pixel values and a truncating average
//   - a frame start that drops an unfinished band
//   - a mode change inside a tile
// It then covers:
//   - a tile count that shrinks inside a band
//   - tile counts of zero, above the maximum, and the maximum itself
//   - many random frames with partial bands and stray frame starts
// The mode and the tile count are written only while the stream is idle.
// A watchdog ends the run if no handshake completes for too long.
// ----------------------------------------------------------------------------
module tile_box_average_or_min_unit_test;
  import tbam_pkg::*;

  localparam int TILE          = 3;
  localparam int MAX_TILES     = 1024;
  localparam int FOLD_W        = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_RUNS   = 6;
  localparam int RUN_ITEMS     = 150;

  typedef struct packed {
    logic             frame_start;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_item_t;

  typedef struct packed {
    logic                 band_done;
    logic [COL_OUT_W-1:0] column;
    logic [PIX_W-1:0]     blue;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     red;
  } tile_result_t;

  typedef struct packed {
    logic [FOLD_W-1:0] r;
    logic [FOLD_W-1:0] g;
    logic [FOLD_W-1:0] b;
  } tile_fold_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic steady = 1'b0;
  int   errors = 0;
  int   stall_cycles = 0;

  pixel_item_t  pixels_to_send[$];
  tile_result_t tiles_due[$];

  tbam_mode_t          m_mode   = MODE_AVERAGE;
  logic [ACROSS_W-1:0] m_across = ACROSS_RESET;
  tile_fold_t          band_fold [MAX_TILES];
  tile_fold_t          running_fold = '0;
  int                  px_col   = 0;
  int                  tile_pos = 0;
  int                  band_row = 0;

  tile_box_average_or_min_unit #(
    .TILE_SIDE(TILE),
    .MAX_TILES(MAX_TILES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [FOLD_W-1:0] fold_ch(input logic [FOLD_W-1:0] acc,
                                                input logic [FOLD_W-1:0] pix);
    if (m_mode == MODE_MINIMUM) return (pix < acc) ? pix : acc;
    return acc + pix;
  endfunction

  function automatic tile_fold_t fold_pair(input tile_fold_t acc, input tile_fold_t pix);
    tile_fold_t f;
    f.r = fold_ch(acc.r, pix.r);
    f.g = fold_ch(acc.g, pix.g);
    f.b = fold_ch(acc.b, pix.b);
    return f;
  endfunction

  function automatic logic [PIX_W-1:0] tile_value(input logic [FOLD_W-1:0] acc);
    logic [FOLD_W-1:0] v;
    v = (m_mode == MODE_AVERAGE) ? FOLD_W'(acc / (TILE * TILE)) : acc;
    return (v > FOLD_W'(255)) ? 8'hFF : v[PIX_W-1:0];
  endfunction

  task automatic pool_pixel(input pixel_item_t px);
    int           across;
    tile_fold_t   pix;
    tile_fold_t   acc;
    tile_result_t res;
    across = (m_across == 0) ? 1 : (m_across > MAX_TILES) ? MAX_TILES : int'(m_across);
    pix.r = FOLD_W'(px.red);
    pix.g = FOLD_W'(px.green);
    pix.b = FOLD_W'(px.blue);
    if (px.frame_start) begin
      px_col   = 0;
      tile_pos = 0;
      band_row = 0;
    end
    if (tile_pos >= across) tile_pos = 0;
    if (px_col == 0 && band_row == 0) acc = pix;
    else if (px_col == 0) acc = fold_pair(band_fold[tile_pos], pix);
    else acc = fold_pair(running_fold, pix);
    px_col++;
    if (px_col < TILE) begin
      running_fold = acc;
      return;
    end
    px_col = 0;
    if (band_row + 1 >= TILE) begin
      res.red       = tile_value(acc.r);
      res.green     = tile_value(acc.g);
      res.blue      = tile_value(acc.b);
      res.column    = tile_pos[COL_OUT_W-1:0];
      res.band_done = (tile_pos + 1 == across);
      tiles_due.push_back(res);
    end else begin
      band_fold[tile_pos] = acc;
    end
    tile_pos++;
    if (tile_pos >= across) begin
      tile_pos = 0;
      band_row++;
      if (band_row >= TILE) band_row = 0;
    end
  endtask

  function automatic pixel_item_t pixel(input logic fs, input logic [PIX_W-1:0] r,
                                        input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    pixel_item_t p;
    p.frame_start = fs;
    p.red         = r;
    p.green       = g;
    p.blue        = b;
    return p;
  endfunction

  function automatic pixel_item_t rand_pixel(input logic fs);
    return pixel(fs, PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                 PIX_W'($urandom_range(255)));
  endfunction

  task automatic queue_pixels(input int count, input logic first_fs);
    for (int i = 0; i < count; i++)
      pixels_to_send.push_back(rand_pixel((i == 0) ? first_fs : 1'b0));
  endtask

  // Mostly whole frames of random content; some end in a partial band, a few
  // carry a stray frame start.
  task automatic queue_random_run(input int across, input int budget);
    int sent;
    int frame_len;
    sent = 0;
    while (sent < budget) begin
      frame_len = $urandom_range(1, 2) * TILE * TILE * across;
      if ($urandom_range(3) == 0) frame_len += $urandom_range(1, TILE * TILE * across - 1);
      for (int i = 0; i < frame_len; i++)
        pixels_to_send.push_back(rand_pixel(i == 0 || $urandom_range(99) < 2));
      sent += frame_len;
    end
  endtask

  task automatic drain();
    while (pixels_to_send.size() != 0 || in_tvalid || tiles_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input tbam_mode_t mode, input logic [ACROSS_W-1:0] across);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    do @(posedge clk); while (!cfg_ready);
    m_mode = mode;
    cfg_index <= CFG_ACROSS;
    cfg_data  <= CFG_DATA_W'(across);
    do @(posedge clk); while (!cfg_ready);
    m_across = across;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pool_pixel(pixels_to_send.pop_front());
      if (!in_tvalid || in_tready) begin
        if (pixels_to_send.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {pixels_to_send[0].blue, pixels_to_send[0].green, pixels_to_send[0].red};
          in_tuser  <= pixels_to_send[0].frame_start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tile_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (tiles_due.size() == 0) begin
          $error("tile result item with none expected, tile_column %0d",
                 out_tdata[3*PIX_W +: COL_OUT_W]);
          errors++;
        end else begin
          want = tiles_due.pop_front();
          check_field("tile_red", 16'(want.red), 16'(out_tdata[0 +: PIX_W]));
          check_field("tile_green", 16'(want.green), 16'(out_tdata[PIX_W +: PIX_W]));
          check_field("tile_blue", 16'(want.blue), 16'(out_tdata[2*PIX_W +: PIX_W]));
          check_field("tile_column", 16'(want.column),
                      16'(out_tdata[3*PIX_W +: COL_OUT_W]));
          check_field("band_done", 16'(want.band_done), 16'(out_tlast));
        end
      end
      out_tready <= steady || $urandom_range(99) >= 9;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tile_box_average_or_min_unit_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    tbam_mode_t mode;
    int         across;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Saturated and empty channels, a truncating average, a dropped band,
    // then a tile left open.
    set_config(MODE_AVERAGE, 11'd1);
    for (int i = 0; i < TILE * TILE; i++)
      pixels_to_send.push_back(pixel(i == 0, 8'd255, 8'd0, (i % 2) ? 8'd254 : 8'd255));
    pixels_to_send.push_back(pixel(1'b0, 8'd200, 8'd200, 8'd200));
    pixels_to_send.push_back(pixel(1'b0, 8'd17, 8'd99, 8'd3));
    for (int i = 0; i < 5; i++)
      pixels_to_send.push_back(pixel(i == 0, 8'd255, 8'd128, 8'd1));
    drain();

    // Finish the open tile as a minimum, then a minimum tile.
    set_config(MODE_MINIMUM, 11'd1);
    for (int i = 0; i < 4; i++)
      pixels_to_send.push_back(pixel(1'b0, PIX_W'(90 + i), 8'd250, 8'd7));
    for (int i = 0; i < TILE * TILE; i++)
      pixels_to_send.push_back(pixel(1'b0, (i == 4) ? 8'd0 : 8'd255,
                                     (i == 8) ? 8'd0 : 8'd255, (i == 0) ? 8'd0 : 8'd255));
    drain();

    // Stop partway into the second row of a band, then shrink the tile count.
    set_config(MODE_AVERAGE, 11'd4);
    queue_pixels(54, 1'b1);
    drain();
    set_config(MODE_AVERAGE, 11'd2);
    queue_pixels(36, 1'b0);
    drain();

    set_config(MODE_MINIMUM, 11'd0);
    queue_pixels(31, 1'b1);
    drain();

    set_config(MODE_MINIMUM, 11'd2047);
    queue_pixels(TILE * 64, 1'b1);
    drain();

    set_config(MODE_AVERAGE, 11'd1024);
    queue_pixels(TILE * 64, 1'b1);
    drain();

    steady <= 1'b1;
    set_config(MODE_AVERAGE, 11'd4);
    queue_pixels(TILE * TILE * 4 * 8, 1'b1);
    drain();
    steady <= 1'b0;

    for (int run = 0; run < RANDOM_RUNS; run++) begin
      mode   = tbam_mode_t'($urandom_range(1));
      across = ($urandom_range(3) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      set_config(mode, ACROSS_W'(across));
      queue_random_run(across, RUN_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("tile_box_average_or_min_unit_test: PASS");
    end else begin
      $display("tile_box_average_or_min_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tbam_pkg.sv
rtl/tbam_pos.sv
rtl/tbam_fold.sv
rtl/tile_box_average_or_min_unit.sv
test/tile_box_average_or_min_unit_test.sv
